// ----- sv/tbds_pkg.sv -----
package tbds_pkg;

   // fixed field widths
   localparam int unsigned CFG_W     = 12;
   localparam int unsigned PIX_W     = 8;
   localparam int unsigned SUM_W     = 12;
   localparam int unsigned OUT_IDX_W = 7;

   // thumbnail index width inside a transaction, wide enough for the largest thumbnail
   localparam int unsigned IDX_MAX_W = 8;

   // decoupling queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // register indexes
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // one point sample handed from front to back
   typedef struct packed {
      logic [PIX_W-1:0]     red;
      logic [PIX_W-1:0]     green;
      logic [PIX_W-1:0]     blue;
      logic [IDX_MAX_W-1:0] col;
      logic [IDX_MAX_W-1:0] row;
      logic [1:0]           sub_col;
      logic                 first_row;
      logic                 last;
      logic                 thumb_last;
   } sample_type;

   // per-column channel sums, each wrapping at 12 bits
   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } csum_type;

   // sum / 12 as (sum >> 2) / 3, the divide by 3 through a reciprocal, exact for every sum below 3072
   function automatic logic [PIX_W-1:0] div12(input logic [SUM_W-1:0] sum);
      logic [20:0] prod;
      prod = 21'(sum[SUM_W-1:2]) * 21'd683;
      return prod[18:11];
   endfunction

endpackage

// ----- sv/tbds_req_if.sv -----
interface tbds_req_if;
   logic                       valid;
   logic                       ready;
   logic [tbds_pkg::PIX_W-1:0] red;
   logic [tbds_pkg::PIX_W-1:0] green;
   logic [tbds_pkg::PIX_W-1:0] blue;
   logic                       frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input frame_start, output ready);
endinterface

// ----- sv/tbds_rsp_if.sv -----
interface tbds_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tbds_pkg::PIX_W-1:0]     out_blue;
   logic [tbds_pkg::PIX_W-1:0]     out_green;
   logic [tbds_pkg::PIX_W-1:0]     out_red;
   logic [tbds_pkg::OUT_IDX_W-1:0] out_col;
   logic [tbds_pkg::OUT_IDX_W-1:0] out_row;
   logic                           thumb_last;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   output out_col, output out_row, output thumb_last, input ready);
   modport sink (input valid, input out_blue, input out_green, input out_red,
                 input out_col, input out_row, input thumb_last, output ready);
endinterface

// ----- sv/thumbnail_box_downsampler_unit.sv -----
// Thumbnail box downsampler: takes a raster stream of RGB source pixels and emits an
// OUT_SIDE x OUT_SIDE thumbnail, each pixel the truncated mean of a 4 x 3 grid of point
// samples, in blue, green, red order with its column and row and a flag on the last pixel
// of the frame. Source pixels are taken at one per clock while the queue is not full: the
// front decides combinationally whether a pixel is a sample and advances the position
// counters, the back adds samples into a per-column sum memory with one read-modify-write
// per sample, and a four-entry queue between them absorbs result back-pressure. A result
// crosses the queue, back stage and output register. Width and height registers may be
// rewritten between frames; the column-sum memory has no reset and needs no clearing.
module thumbnail_box_downsampler_unit #(
   parameter int unsigned OUT_SIDE = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   tbds_req_if.sink                        req_chan,
   tbds_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [0:0]                      csr_index,
   input  logic [tbds_pkg::CFG_W-1:0]      csr_wdata
);

   logic [tbds_pkg::CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic                       q_push, q_full, q_pop, q_empty;
   tbds_pkg::sample_type       q_in, q_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= tbds_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= tbds_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tbds_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            tbds_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
         endcase
      end
   end

   tbds_front #(
      .OUT_SIDE (OUT_SIDE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   tbds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   tbds_back #(
      .OUT_SIDE (OUT_SIDE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_out),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- sv/tbds_front.sv -----
module tbds_front #(
   parameter int unsigned OUT_SIDE
) (
   input  logic                          clock,
   input  logic                          reset,
   tbds_req_if.sink                      req_chan,
   input  logic [tbds_pkg::CFG_W-1:0]    frame_width,
   input  logic [tbds_pkg::CFG_W-1:0]    frame_height,
   input  logic                          q_full,
   output logic                          q_push,
   output tbds_pkg::sample_type          q_data
);

   localparam int unsigned NC  = 4 * OUT_SIDE;
   localparam int unsigned NR  = 3 * OUT_SIDE;
   localparam int unsigned CIW = $clog2(NC + 1);
   localparam int unsigned RIW = $clog2(NR + 1);
   localparam int unsigned CPW = CIW + tbds_pkg::CFG_W;
   localparam int unsigned RPW = RIW + tbds_pkg::CFG_W;
   localparam int unsigned TW  = $clog2(OUT_SIDE + 1);

   logic [tbds_pkg::CFG_W-1:0] w_eff, h_eff;
   logic                       accept, fs;
   logic                       row_hit, col_hit, line_end, frame_end;

   logic [tbds_pkg::CFG_W-1:0] src_col_ff, src_col_in, scol;
   logic [tbds_pkg::CFG_W-1:0] src_row_ff, src_row_in, srow;
   logic [CIW-1:0]             col_idx_ff, col_idx_in, col_idx_cur, col_idx_inc;
   logic [RIW-1:0]             row_idx_ff, row_idx_in, row_idx_cur, row_idx_inc;
   logic [CPW-1:0]             col_prod_ff, col_prod_in, col_prod_cur, col_prod_inc;
   logic [CPW-1:0]             col_base_ff, col_base_in, col_base_cur, col_diff;
   logic [RPW-1:0]             row_prod_ff, row_prod_in, row_prod_cur, row_prod_inc;
   logic [RPW-1:0]             row_base_ff, row_base_in, row_base_cur, row_diff;
   logic [1:0]                 row_sub_ff, row_sub_in, row_sub_cur;
   logic [TW-1:0]              rt_ff, rt_in, rt_cur;

   // sizes below the sample grid behave as the grid size
   assign w_eff = (frame_width < tbds_pkg::CFG_W'(NC)) ? tbds_pkg::CFG_W'(NC) : frame_width;
   assign h_eff = (frame_height < tbds_pkg::CFG_W'(NR)) ? tbds_pkg::CFG_W'(NR) : frame_height;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign fs             = req_chan.frame_start;

   // position state as seen by this pixel, frame start restarts it
   assign scol         = fs ? '0 : src_col_ff;
   assign srow         = fs ? '0 : src_row_ff;
   assign col_idx_cur  = fs ? '0 : col_idx_ff;
   assign row_idx_cur  = fs ? '0 : row_idx_ff;
   assign col_prod_cur = fs ? '0 : col_prod_ff;
   assign col_base_cur = fs ? '0 : col_base_ff;
   assign row_prod_cur = fs ? '0 : row_prod_ff;
   assign row_base_cur = fs ? '0 : row_base_ff;
   assign row_sub_cur  = fs ? '0 : row_sub_ff;
   assign rt_cur       = fs ? '0 : rt_ff;

   // sample position idx*size/n matches pos when pos*n <= idx*size < pos*n + n
   assign row_diff = row_prod_cur - row_base_cur;
   assign col_diff = col_prod_cur - col_base_cur;
   assign row_hit  = (row_idx_cur < RIW'(NR)) && (row_prod_cur >= row_base_cur)
                     && (row_diff < RPW'(NR));
   assign col_hit  = row_hit && (col_idx_cur < CIW'(NC)) && (col_prod_cur >= col_base_cur)
                     && (col_diff < CPW'(NC));

   // products for the next sample column and row, taken at the current size
   assign col_idx_inc  = col_idx_cur + CIW'(1);
   assign row_idx_inc  = row_idx_cur + RIW'(1);
   assign col_prod_inc = CPW'(col_idx_inc) * CPW'(w_eff);
   assign row_prod_inc = RPW'(row_idx_inc) * RPW'(h_eff);

   assign line_end  = ({1'b0, scol} + 13'd1) >= {1'b0, w_eff};
   assign frame_end = ({1'b0, srow} + 13'd1) >= {1'b0, h_eff};

   // sample transaction to the back
   assign q_push = accept && col_hit;
   always_comb begin
      q_data.red        = req_chan.red;
      q_data.green      = req_chan.green;
      q_data.blue       = req_chan.blue;
      q_data.col        = tbds_pkg::IDX_MAX_W'(col_idx_cur[CIW-1:2]);
      q_data.row        = tbds_pkg::IDX_MAX_W'(rt_cur);
      q_data.sub_col    = col_idx_cur[1:0];
      q_data.first_row  = (row_sub_cur == 2'd0);
      q_data.last       = (col_idx_cur[1:0] == 2'd3) && (row_sub_cur == 2'd2);
      q_data.thumb_last = (col_idx_cur[CIW-1:2] == (CIW-2)'(OUT_SIDE - 1))
                          && (rt_cur == TW'(OUT_SIDE - 1));
   end

   // position counters
   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      col_idx_in  = col_idx_ff;
      row_idx_in  = row_idx_ff;
      col_prod_in = col_prod_ff;
      col_base_in = col_base_ff;
      row_prod_in = row_prod_ff;
      row_base_in = row_base_ff;
      row_sub_in  = row_sub_ff;
      rt_in       = rt_ff;
      if (accept) begin
         src_col_in  = scol;
         src_row_in  = srow;
         col_idx_in  = col_idx_cur;
         row_idx_in  = row_idx_cur;
         col_prod_in = col_prod_cur;
         col_base_in = col_base_cur;
         row_prod_in = row_prod_cur;
         row_base_in = row_base_cur;
         row_sub_in  = row_sub_cur;
         rt_in       = rt_cur;
         if (col_hit) begin
            col_idx_in  = col_idx_inc;
            col_prod_in = col_prod_inc;
         end
         if (line_end) begin
            src_col_in  = '0;
            col_base_in = '0;
            col_idx_in  = '0;
            col_prod_in = '0;
            if (row_hit) begin
               row_idx_in  = row_idx_inc;
               row_prod_in = row_prod_inc;
               if (row_sub_cur == 2'd2) begin
                  row_sub_in = 2'd0;
                  rt_in      = rt_cur + TW'(1);
               end else begin
                  row_sub_in = row_sub_cur + 2'd1;
               end
            end
            if (frame_end) begin
               src_row_in  = '0;
               row_base_in = '0;
               row_idx_in  = '0;
               row_prod_in = '0;
               row_sub_in  = '0;
               rt_in       = '0;
            end else begin
               src_row_in  = srow + tbds_pkg::CFG_W'(1);
               row_base_in = row_base_cur + RPW'(NR);
            end
         end else begin
            src_col_in  = scol + tbds_pkg::CFG_W'(1);
            col_base_in = col_base_cur + CPW'(NC);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         col_idx_ff  <= '0;
         row_idx_ff  <= '0;
         col_prod_ff <= '0;
         col_base_ff <= '0;
         row_prod_ff <= '0;
         row_base_ff <= '0;
         row_sub_ff  <= '0;
         rt_ff       <= '0;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         col_idx_ff  <= col_idx_in;
         row_idx_ff  <= row_idx_in;
         col_prod_ff <= col_prod_in;
         col_base_ff <= col_base_in;
         row_prod_ff <= row_prod_in;
         row_base_ff <= row_base_in;
         row_sub_ff  <= row_sub_in;
         rt_ff       <= rt_in;
      end
   end

endmodule

// ----- sv/tbds_queue.sv -----
module tbds_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tbds_pkg::sample_type push_data,
   output logic                 full,
   input  logic                 pop,
   output tbds_pkg::sample_type pop_data,
   output logic                 empty
);

   tbds_pkg::sample_type                entries [tbds_pkg::QUEUE_DEPTH];
   logic [tbds_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [tbds_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full     = (count_ff == tbds_pkg::QCNT_W'(tbds_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tbds_pkg::QPTR_W'(tbds_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + tbds_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tbds_pkg::QPTR_W'(tbds_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + tbds_pkg::QPTR_W'(1);
      end
      count_in = count_ff + tbds_pkg::QCNT_W'(push) - tbds_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(full && push))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(empty && pop))
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + tbds_pkg::QCNT_W'(1)))
      else $error("queue fill count lost a transaction");
`endif

endmodule

// ----- sv/tbds_back.sv -----
module tbds_back #(
   parameter int unsigned OUT_SIDE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  tbds_pkg::sample_type q_head,
   output logic                 q_pop,
   tbds_rsp_if.source           rsp_chan
);

   localparam int unsigned CW = $clog2(OUT_SIDE);

   tbds_pkg::csum_type           sums_mem [OUT_SIDE];
   tbds_pkg::csum_type           rd_ff, byp_data_ff, acc_ff, base, sum;
   tbds_pkg::sample_type         b2_ff;
   logic                         b2_valid_ff, b2_valid_in, b2_go, byp_valid_ff;
   logic [CW-1:0]                b2_addr, head_addr;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tbds_pkg::PIX_W-1:0]       rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic [tbds_pkg::OUT_IDX_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic                             rsp_thumb_last_ff;

   assign b2_addr   = b2_ff.col[CW-1:0];
   assign head_addr = q_head.col[CW-1:0];

   // a sample that closes a thumbnail pixel needs the output register free
   assign b2_go = b2_valid_ff && (!b2_ff.last || !rsp_valid_ff || rsp_chan.ready);
   assign q_pop = !q_empty && (!b2_valid_ff || b2_go);
   assign b2_valid_in = q_pop ? 1'b1 : (b2_go ? 1'b0 : b2_valid_ff);

   // accumulate: first sub-column restarts from the stored column sum, or from zero on the first row
   always_comb begin
      if (b2_ff.sub_col == 2'd0) begin
         if (b2_ff.first_row) begin
            base = '0;
         end else begin
            base = byp_valid_ff ? byp_data_ff : rd_ff;
         end
      end else begin
         base = acc_ff;
      end
      sum.red   = base.red + tbds_pkg::SUM_W'(b2_ff.red);
      sum.green = base.green + tbds_pkg::SUM_W'(b2_ff.green);
      sum.blue  = base.blue + tbds_pkg::SUM_W'(b2_ff.blue);
   end

   // output register
   assign rsp_valid_in = (b2_go && b2_ff.last) ? 1'b1
                         : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff  <= b2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            byp_valid_ff <= b2_go && (b2_addr == head_addr);
         end
      end
   end

   // stage payload, read data and same-address forwarding
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b2_ff       <= q_head;
         rd_ff       <= sums_mem[head_addr];
         byp_data_ff <= sum;
      end
      if (b2_go) begin
         sums_mem[b2_addr] <= sum;
         acc_ff            <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_go && b2_ff.last) begin
         rsp_blue_ff       <= tbds_pkg::div12(sum.blue);
         rsp_green_ff      <= tbds_pkg::div12(sum.green);
         rsp_red_ff        <= tbds_pkg::div12(sum.red);
         rsp_col_ff        <= tbds_pkg::OUT_IDX_W'(b2_ff.col);
         rsp_row_ff        <= tbds_pkg::OUT_IDX_W'(b2_ff.row);
         rsp_thumb_last_ff <= b2_ff.thumb_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_blue   = rsp_blue_ff;
   assign rsp_chan.out_green  = rsp_green_ff;
   assign rsp_chan.out_red    = rsp_red_ff;
   assign rsp_chan.out_col    = rsp_col_ff;
   assign rsp_chan.out_row    = rsp_row_ff;
   assign rsp_chan.thumb_last = rsp_thumb_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (b2_go && b2_ff.last) |=> rsp_valid_ff)
      else $error("closing sample did not load a result");
   assert property (@(posedge clock) disable iff (reset)
      (b2_valid_ff && !b2_go) |=> (b2_valid_ff && $stable(b2_ff)))
      else $error("stalled sample changed");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_thumb_last_ff)
      |-> (rsp_col_ff == tbds_pkg::OUT_IDX_W'(OUT_SIDE - 1)
           && rsp_row_ff == tbds_pkg::OUT_IDX_W'(OUT_SIDE - 1)))
      else $error("frame end flagged away from the last thumbnail pixel");
`endif

endmodule

// ----- sim/thumb_pixel_checker.sv -----
`timescale 1ns / 1ps

module thumb_pixel_checker (
   input  logic                       clock,
   input  logic                       reset,
   tbds_req_if                        req_mon,
   tbds_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [tbds_pkg::CFG_W-1:0] csr_wdata,
   output int unsigned                mismatch_count,
   output int unsigned                pending_count
);

   localparam int unsigned THUMB_SIDE  = 128;
   localparam int unsigned SAMPLE_COLS = 4 * THUMB_SIDE;
   localparam int unsigned SAMPLE_ROWS = 3 * THUMB_SIDE;

   typedef struct packed {
      logic [tbds_pkg::PIX_W-1:0]     blue;
      logic [tbds_pkg::PIX_W-1:0]     green;
      logic [tbds_pkg::PIX_W-1:0]     red;
      logic [tbds_pkg::OUT_IDX_W-1:0] col;
      logic [tbds_pkg::OUT_IDX_W-1:0] row;
      logic                           is_last;
   } thumb_pixel_type;

   // shadow copy of the size registers
   logic [tbds_pkg::CFG_W-1:0] frame_width;
   logic [tbds_pkg::CFG_W-1:0] frame_height;

   // raster position and sample grid tracking
   logic [11:0]        src_col;
   logic [11:0]        src_row;
   logic [9:0]         samp_col;
   logic [9:0]         samp_row;
   logic [11:0]        next_col_pos;
   logic [11:0]        next_row_pos;
   tbds_pkg::csum_type col_sums [THUMB_SIDE];

   thumb_pixel_type thumb_pixels_due [$];
   thumb_pixel_type seen_pixel;
   thumb_pixel_type due_pixel;
   int unsigned     mismatches;

   function automatic void restart_grid();
      src_col      = '0;
      src_row      = '0;
      samp_col     = '0;
      samp_row     = '0;
      next_col_pos = '0;
      next_row_pos = '0;
   endfunction

   // advance the sample grid by one source pixel, queue the thumbnail pixel it completes
   function automatic void take_source_pixel(input logic [tbds_pkg::PIX_W-1:0] red,
                                             input logic [tbds_pkg::PIX_W-1:0] green,
                                             input logic [tbds_pkg::PIX_W-1:0] blue,
                                             input logic                       frame_start);
      int unsigned        w;
      int unsigned        h;
      logic               row_hit;
      logic [6:0]         tcol;
      logic [1:0]         sub_c;
      int unsigned        sub_r;
      tbds_pkg::csum_type s;
      thumb_pixel_type    px;
      // sizes below the sample grid saturate to it
      w = (frame_width < SAMPLE_COLS) ? SAMPLE_COLS : 32'(frame_width);
      h = (frame_height < SAMPLE_ROWS) ? SAMPLE_ROWS : 32'(frame_height);
      if (frame_start) restart_grid();
      row_hit = (samp_row < SAMPLE_ROWS) && (src_row == next_row_pos);

      // point sample hit: accumulate into the column sum
      if (row_hit && samp_col < SAMPLE_COLS && src_col == next_col_pos) begin
         tcol  = samp_col[8:2];
         sub_c = samp_col[1:0];
         sub_r = 32'(samp_row) % 3;
         if (sub_c == 2'd0 && sub_r == 0) s = '0;
         else s = col_sums[tcol];
         s.red   = s.red + tbds_pkg::SUM_W'(red);
         s.green = s.green + tbds_pkg::SUM_W'(green);
         s.blue  = s.blue + tbds_pkg::SUM_W'(blue);
         col_sums[tcol] = s;
         if (sub_c == 2'd3 && sub_r == 2) begin
            px.blue    = tbds_pkg::PIX_W'(s.blue / 12);
            px.green   = tbds_pkg::PIX_W'(s.green / 12);
            px.red     = tbds_pkg::PIX_W'(s.red / 12);
            px.col     = tcol;
            px.row     = tbds_pkg::OUT_IDX_W'(32'(samp_row) / 3);
            px.is_last = (tcol == 7'(THUMB_SIDE - 1)) && (px.row == 7'(THUMB_SIDE - 1));
            thumb_pixels_due.push_back(px);
         end
         samp_col     = samp_col + 10'd1;
         next_col_pos = 12'((32'(samp_col) * w) / SAMPLE_COLS);
      end

      // end of line, end of frame wraps as a restart
      if (32'(src_col) + 1 >= w) begin
         src_col      = '0;
         samp_col     = '0;
         next_col_pos = '0;
         if (row_hit) begin
            samp_row     = samp_row + 10'd1;
            next_row_pos = 12'((32'(samp_row) * h) / SAMPLE_ROWS);
         end
         if (32'(src_row) + 1 >= h) restart_grid();
         else src_row = src_row + 12'd1;
      end else begin
         src_col = src_col + 12'd1;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // monitor both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         frame_width  = tbds_pkg::FRAME_WIDTH_RESET;
         frame_height = tbds_pkg::FRAME_HEIGHT_RESET;
         restart_grid();
         foreach (col_sums[k]) col_sums[k] = '0;
         thumb_pixels_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tbds_pkg::CSR_FRAME_WIDTH:  frame_width = csr_wdata;
               tbds_pkg::CSR_FRAME_HEIGHT: frame_height = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            take_source_pixel(req_mon.red, req_mon.green, req_mon.blue, req_mon.frame_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_pixel.blue    = rsp_mon.out_blue;
            seen_pixel.green   = rsp_mon.out_green;
            seen_pixel.red     = rsp_mon.out_red;
            seen_pixel.col     = rsp_mon.out_col;
            seen_pixel.row     = rsp_mon.out_row;
            seen_pixel.is_last = rsp_mon.thumb_last;
            if (thumb_pixels_due.size() == 0) begin
               $error("unexpected thumbnail pixel at col %0d row %0d",
                      seen_pixel.col, seen_pixel.row);
               mismatches++;
            end else begin
               due_pixel = thumb_pixels_due.pop_front();
               check_field("out_blue", due_pixel.blue, seen_pixel.blue);
               check_field("out_green", due_pixel.green, seen_pixel.green);
               check_field("out_red", due_pixel.red, seen_pixel.red);
               check_field("out_col", due_pixel.col, seen_pixel.col);
               check_field("out_row", due_pixel.row, seen_pixel.row);
               check_field("thumb_last", due_pixel.is_last, seen_pixel.is_last);
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= thumb_pixels_due.size();
   end

endmodule

// ----- sim/thumbnail_box_downsampler_unit_tb.sv -----
`timescale 1ns / 1ps

module thumbnail_box_downsampler_unit_tb;

   localparam longint      TIMEOUT_NS    = 250_000_000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned DRAIN_LIMIT   = 100_000;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned HOLD_AT       = 40;

   typedef enum int unsigned {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY, IDLE_MIXED} idle_style_type;
   typedef enum int unsigned {FILL_NOISE, FILL_MAX, FILL_ZERO, FILL_EXTREME} fill_type;

   // opening pixels {frame_start, red, green, blue}: extremes, bit patterns, mid-line restart
   localparam logic [24:0] DIRECTED_PIXELS [0:13] = '{
      {1'b1, 8'h00, 8'h00, 8'h00},
      {1'b0, 8'hFF, 8'hFF, 8'hFF},
      {1'b0, 8'hFF, 8'h00, 8'h00},
      {1'b0, 8'h00, 8'hFF, 8'h00},
      {1'b0, 8'h00, 8'h00, 8'hFF},
      {1'b0, 8'hAA, 8'h55, 8'hAA},
      {1'b0, 8'h55, 8'hAA, 8'h55},
      {1'b0, 8'h01, 8'h80, 8'h7F},
      {1'b1, 8'hFF, 8'hFF, 8'hFF},
      {1'b0, 8'hFF, 8'hFF, 8'hFF},
      {1'b0, 8'h00, 8'h00, 8'h00},
      {1'b1, 8'h12, 8'h34, 8'h56},
      {1'b1, 8'hFE, 8'hEF, 8'h7E},
      {1'b0, 8'h80, 8'h01, 8'hFF}
   };

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [0:0]                 csr_index;
   logic [tbds_pkg::CFG_W-1:0] csr_wdata;
   int unsigned                mismatch_count;
   int unsigned                pending_count;
   int unsigned                cur_width;
   bit                         rsp_light_only;

   tbds_req_if req_bus ();
   tbds_rsp_if rsp_bus ();

   thumbnail_box_downsampler_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   thumb_pixel_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned draw_gap(input idle_style_type style);
      case (style)
         IDLE_LIGHT: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : 0;
         IDLE_HEAVY: return $urandom_range(0, 15);
         default:    return 0;
      endcase
   endfunction

   function automatic idle_style_type pick_style(input bit light_only);
      if (light_only) return ($urandom_range(0, 1) == 1) ? IDLE_LIGHT : IDLE_NONE;
      case ($urandom_range(0, 2))
         0:       return IDLE_NONE;
         1:       return IDLE_LIGHT;
         default: return IDLE_HEAVY;
      endcase
   endfunction

   // result side: random stalls per transaction, one long hold to back up the queue
   initial begin : result_drain
      int unsigned    gap_left;
      int unsigned    taken;
      bit             held;
      idle_style_type style;
      gap_left = 0;
      taken    = 0;
      held     = 1'b0;
      style    = IDLE_NONE;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (gap_left > 0) begin
            rsp_bus.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            taken++;
            if (taken % 64 == 0) style = pick_style(rsp_light_only);
            if (!held && taken == HOLD_AT) begin
               gap_left = HOLD_CYCLES;
               held     = 1'b1;
            end else begin
               gap_left = draw_gap(style);
            end
         end
      end
   end

   // offer one source pixel after an idle gap, return once the transaction is taken
   task automatic send_pixel(input logic [tbds_pkg::PIX_W-1:0] red,
                             input logic [tbds_pkg::PIX_W-1:0] green,
                             input logic [tbds_pkg::PIX_W-1:0] blue, input logic frame_start,
                             input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.red         <= red;
      req_bus.green       <= green;
      req_bus.blue        <= blue;
      req_bus.frame_start <= frame_start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // raster stream with column strips of solid or random content
   task automatic send_block(input int unsigned count, input bit restart,
                             input idle_style_type style, input int unsigned noise_per_mille);
      idle_style_type cur;
      int unsigned    line_len;
      int unsigned    strip;
      fill_type       strip_fill [64];
      logic [23:0]    rgb;
      logic           fs;
      line_len = (cur_width < 512) ? 512 : cur_width;
      foreach (strip_fill[k])
         strip_fill[k] = ($urandom_range(0, 7) < 4) ? FILL_NOISE
                                                    : fill_type'($urandom_range(1, 3));
      cur = (style == IDLE_MIXED) ? pick_style(1'b0) : style;
      for (int unsigned i = 0; i < count; i++) begin
         if (style == IDLE_MIXED && i % 128 == 0) cur = pick_style(1'b0);
         strip = ((i % line_len) / 64) % 64;
         case (strip_fill[strip])
            FILL_MAX:     rgb = 24'hFFFFFF;
            FILL_ZERO:    rgb = 24'h000000;
            FILL_EXTREME: rgb = {($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                                 ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                                 ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00};
            default:      rgb = 24'($urandom());
         endcase
         fs = (i == 0) ? restart : ($urandom_range(0, 999) < noise_per_mille);
         send_pixel(rgb[23:16], rgb[15:8], rgb[7:0], fs, draw_gap(cur));
      end
   endtask

   // stop offering and wait until the block has nothing left in flight
   task automatic settle();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input tbds_pkg::csr_index_type idx,
                            input logic [tbds_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == tbds_pkg::CSR_FRAME_WIDTH) cur_width = value;
   endtask

   task automatic set_size(input logic [tbds_pkg::CFG_W-1:0] w,
                           input logic [tbds_pkg::CFG_W-1:0] h);
      write_reg(tbds_pkg::CSR_FRAME_WIDTH, w);
      write_reg(tbds_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.red         = '0;
      req_bus.green       = '0;
      req_bus.blue        = '0;
      req_bus.frame_start = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      cur_width           = tbds_pkg::FRAME_WIDTH_RESET;
      rsp_light_only      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size: directed opening, then a short random stretch
      foreach (DIRECTED_PIXELS[k])
         send_pixel(DIRECTED_PIXELS[k][23:16], DIRECTED_PIXELS[k][15:8],
                    DIRECTED_PIXELS[k][7:0], DIRECTED_PIXELS[k][24],
                    draw_gap(IDLE_HEAVY));
      send_block(186, 1'b0, IDLE_HEAVY, 0);
      settle();

      // sizes below the grid saturate; a full thumbnail row with the long hold
      set_size(12'd0, 12'd100);
      send_block(1600, 1'b1, IDLE_MIXED, 0);
      settle();

      // frequent stray frame starts
      set_size(12'd600, 12'd400);
      send_block(200, 1'b1, IDLE_HEAVY, 5);
      settle();

      if (mismatch_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
